FILE: hw/rtl/manchester_framer_crc32_defines.svh
// Assertion macros for the Manchester framer.
// The enclosing module must have clk and rst_n in scope.
`ifndef MANCHESTER_FRAMER_CRC32_DEFINES_SVH
`define MANCHESTER_FRAMER_CRC32_DEFINES_SVH

// Clocked check, disabled while reset is asserted.
`define MCF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication check: cause in one cycle, effect in the next.
`define MCF_ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

FILE: hw/rtl/mcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcf_pkg: shared definitions for the Manchester framer
// CRC-32 constants, register indexes, reset values and the byte-level
// CRC and Manchester encode functions.
// ----------------------------------------------------------------------------
package mcf_pkg;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [7:0] PREAMBLE_VALUE_RST = 8'h55;
    localparam logic [3:0] PREAMBLE_COUNT_RST = 4'd4;
    localparam logic [7:0] SYNC_VALUE_RST     = 8'h7E;

    localparam logic [15:0] LEN_OVERHEAD = 16'd4;

    localparam logic [1:0] CFG_PREAMBLE_VALUE = 2'd0;
    localparam logic [1:0] CFG_PREAMBLE_COUNT = 2'd1;
    localparam logic [1:0] CFG_SYNC_VALUE     = 2'd2;

    // Reflected CRC-32 over one byte: eight shift/xor steps.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int j = 0; j < 8; j++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    // MSB first; a one is high then low, a zero low then high.
    function automatic logic [15:0] manchester(input logic [7:0] b);
        logic [15:0] w;
        w = '0;
        for (int i = 0; i < 8; i++)
        begin
            w[2*i+1] = b[i];
            w[2*i]   = ~b[i];
        end
        return w;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/manchester_framer_crc32.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// manchester_framer_crc32: byte framer with CRC-32 trailer and Manchester code
// Wraps payload bytes in preamble, sync and length header, appends a
// reflected CRC-32 low byte first, and emits every byte as a 16-bit
// Manchester word.
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------
//   in      | in_valid / in_ready    | data_byte, frame_start, frame_end,
//           |                        | payload_length
//   out     | out_valid / out_ready  | symbol_word, frame_done
//   cfg     | cfg_write              | cfg_index, cfg_data
//
// One output word leaves per cycle while out_ready is high. A middle payload
// byte gives one word, so such bytes stream back to back; the single word
// sequencer sends a first byte as preamble, sync, length and data words, a
// last byte as data and CRC words. Bytes outside a frame are dropped. Reset
// presets the CRC, clears the frame flag, the sequencer and output valid and
// loads register defaults. A stalled output holds its word and the sequencer.
// ----------------------------------------------------------------------------
`include "manchester_framer_crc32_defines.svh"

module manchester_framer_crc32
    import mcf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_start,
    input  wire logic        frame_end,
    input  wire logic [15:0] payload_length,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      symbol_word,
    output logic             frame_done
);

    typedef enum logic [3:0] {
        PH_PRE,
        PH_SYNC,
        PH_LENH,
        PH_LENL,
        PH_DATA,
        PH_CRC0,
        PH_CRC1,
        PH_CRC2,
        PH_CRC3
    } phase_t;

    logic [7:0]  preamble_value_reg;
    logic [3:0]  preamble_count_reg;
    logic [7:0]  sync_value_reg;

    logic [31:0] crc_reg,      crc_next;
    logic        in_frame_reg, in_frame_next;

    // Held item being sequenced into words.
    logic        hold_valid_reg, hold_valid_next;
    phase_t      phase_reg,      phase_next;
    logic [3:0]  pre_cnt_reg,    pre_cnt_next;
    logic [7:0]  data_reg,       data_next;
    logic        end_reg,        end_next;
    logic [15:0] flen_reg,       flen_next;
    logic [31:0] fcs_reg,        fcs_next;

    logic        out_valid_reg,  out_valid_next;
    logic [15:0] word_reg,       word_next;
    logic        done_reg,       done_next;

    logic        accept;
    logic        emit;
    logic        last_word;
    logic        take;
    logic [31:0] crc_upd;
    logic [7:0]  cur_byte;

    assign emit      = hold_valid_reg && (!out_valid_reg || out_ready);
    assign last_word = (phase_reg == PH_DATA && !end_reg) || (phase_reg == PH_CRC3);
    assign in_ready  = !hold_valid_reg || (emit && last_word);
    assign accept    = in_valid && in_ready;
    // Items outside a frame are consumed but produce nothing.
    assign take      = accept && (frame_start || in_frame_reg);
    assign crc_upd   = crc32_byte(frame_start ? CRC_INIT : crc_reg, data_byte);

    always_comb
    begin
        case (phase_reg)
            PH_PRE:  cur_byte = preamble_value_reg;
            PH_SYNC: cur_byte = sync_value_reg;
            PH_LENH: cur_byte = flen_reg[15:8];
            PH_LENL: cur_byte = flen_reg[7:0];
            PH_DATA: cur_byte = data_reg;
            PH_CRC0: cur_byte = fcs_reg[7:0];
            PH_CRC1: cur_byte = fcs_reg[15:8];
            PH_CRC2: cur_byte = fcs_reg[23:16];
            PH_CRC3: cur_byte = fcs_reg[31:24];
            default: cur_byte = data_reg;
        endcase
    end

    always_comb
    begin
        crc_next        = crc_reg;
        in_frame_next   = in_frame_reg;
        hold_valid_next = hold_valid_reg;
        phase_next      = phase_reg;
        pre_cnt_next    = pre_cnt_reg;
        data_next       = data_reg;
        end_next        = end_reg;
        flen_next       = flen_reg;
        fcs_next        = fcs_reg;
        out_valid_next  = out_valid_reg;
        word_next       = word_reg;
        done_next       = done_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Advance the sequencer one word.
        if (emit)
        begin
            out_valid_next = 1'b1;
            word_next      = manchester(cur_byte);
            done_next      = (phase_reg == PH_CRC3);
            case (phase_reg)
                PH_PRE:
                begin
                    pre_cnt_next = pre_cnt_reg + 4'd1;
                    if (pre_cnt_reg == preamble_count_reg - 4'd1)
                    begin
                        phase_next = PH_SYNC;
                    end
                end
                PH_SYNC: phase_next = PH_LENH;
                PH_LENH: phase_next = PH_LENL;
                PH_LENL: phase_next = PH_DATA;
                PH_DATA:
                begin
                    if (end_reg)
                    begin
                        phase_next = PH_CRC0;
                    end
                    else
                    begin
                        hold_valid_next = 1'b0;
                    end
                end
                PH_CRC0: phase_next = PH_CRC1;
                PH_CRC1: phase_next = PH_CRC2;
                PH_CRC2: phase_next = PH_CRC3;
                PH_CRC3: hold_valid_next = 1'b0;
                default: hold_valid_next = 1'b0;
            endcase
        end

        // Load a new beat; the CRC is folded in as it is taken.
        if (take)
        begin
            hold_valid_next = 1'b1;
            data_next       = data_byte;
            end_next        = frame_end;
            flen_next       = payload_length + LEN_OVERHEAD;
            fcs_next        = ~crc_upd;
            pre_cnt_next    = '0;
            if (frame_start)
            begin
                phase_next = (preamble_count_reg != 4'd0) ? PH_PRE : PH_SYNC;
            end
            else
            begin
                phase_next = PH_DATA;
            end
            crc_next      = frame_end ? CRC_INIT : crc_upd;
            in_frame_next = !frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_value_reg <= PREAMBLE_VALUE_RST;
            preamble_count_reg <= PREAMBLE_COUNT_RST;
            sync_value_reg     <= SYNC_VALUE_RST;
            crc_reg            <= CRC_INIT;
            in_frame_reg       <= 1'b0;
            hold_valid_reg     <= 1'b0;
            phase_reg          <= PH_DATA;
            pre_cnt_reg        <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PREAMBLE_VALUE: preamble_value_reg <= cfg_data;
                    CFG_PREAMBLE_COUNT: preamble_count_reg <= cfg_data[3:0];
                    CFG_SYNC_VALUE:     sync_value_reg     <= cfg_data;
                    default:            ;
                endcase
            end
            crc_reg        <= crc_next;
            in_frame_reg   <= in_frame_next;
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
            pre_cnt_reg    <= pre_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        end_reg  <= end_next;
        flen_reg <= flen_next;
        fcs_reg  <= fcs_next;
        word_reg <= word_next;
        done_reg <= done_next;
    end

    assign out_valid   = out_valid_reg;
    assign symbol_word = word_reg;
    assign frame_done  = done_reg;

    `MCF_ASSERT(a_idle_crc, !in_frame_reg |-> (crc_reg == CRC_INIT), "CRC not at init outside a frame")
    `MCF_ASSERT(a_busy, !in_ready |-> hold_valid_reg, "input stalled with no held beat")
    `MCF_ASSERT(a_pre_cnt, (hold_valid_reg && phase_reg == PH_PRE) |-> (pre_cnt_reg < preamble_count_reg), "preamble count overrun")
    `MCF_ASSERT_NEXT(a_done_clear, emit && phase_reg == PH_CRC3 && !take, !hold_valid_reg, "sequencer busy after trailer")

endmodule
`default_nettype wire
